/* sv/lsf_pkg.sv */
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants and types of the least-squares line fit block.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_SET_POINTS = 1024;
  localparam int FRAC_BITS      = 16;

  localparam int PT_W    = 8;
  localparam int CNT_W   = $clog2(MAX_SET_POINTS + 1);
  localparam int SX_W    = CNT_W + PT_W;
  localparam int SXX_W   = CNT_W + 2 * PT_W;
  localparam int PROD_W  = SX_W + SXX_W;
  localparam int DVD_W   = PROD_W + FRAC_BITS;
  localparam int RES_W   = 32;
  localparam int NUM_MUL = 6;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [RES_W-1:0] Q_MAX     = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] Q_MIN     = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic [RES_W-1:0] SLOPE_INF = Q_MAX;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SX_W-1:0]  sx;
    logic [SX_W-1:0]  sy;
    logic [SXX_W-1:0] sxy;
    logic [SXX_W-1:0] sxx;
  } sums_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] den;
  } div_req_t;

endpackage

/* sv/lsf_front.sv */
// ----------------------------------------------------------------------------
// lsf_front
// Accepts points, keeps the running sums and hands a snapshot of them to the
// queue on the item that closes a set.
// ----------------------------------------------------------------------------
module lsf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lsf_pkg::PT_W-1:0]   in_point_x,
  input  logic [lsf_pkg::PT_W-1:0]   in_point_y,
  input  logic                       in_has_point,
  input  logic                       in_last_point,
  input  logic                       q_full,
  output logic                       q_push,
  output lsf_pkg::sums_t             q_data
);

  lsf_pkg::sums_t sums_r;
  lsf_pkg::sums_t sums_nxt;
  logic           accept;
  logic           add;
  logic [2*lsf_pkg::PT_W-1:0] xy;
  logic [2*lsf_pkg::PT_W-1:0] xx;

  assign in_stall = q_full & in_last_point;
  assign accept   = in_valid & ~in_stall;
  assign add      = in_has_point &
                    (sums_r.cnt < lsf_pkg::CNT_W'(lsf_pkg::MAX_SET_POINTS));
  assign xy       = in_point_x * in_point_y;
  assign xx       = in_point_x * in_point_x;

  always_comb begin
    sums_nxt = sums_r;
    if (add) begin
      sums_nxt.cnt = sums_r.cnt + 1'b1;
      sums_nxt.sx  = sums_r.sx + lsf_pkg::SX_W'(in_point_x);
      sums_nxt.sy  = sums_r.sy + lsf_pkg::SX_W'(in_point_y);
      sums_nxt.sxy = sums_r.sxy + lsf_pkg::SXX_W'(xy);
      sums_nxt.sxx = sums_r.sxx + lsf_pkg::SXX_W'(xx);
    end
  end

  assign q_push = accept & in_last_point;
  assign q_data = sums_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else if (accept) begin
      if (in_last_point) begin
        sums_r <= '0;
      end else begin
        sums_r <= sums_nxt;
      end
    end
  end

endmodule

/* sv/lsf_queue.sv */
// ----------------------------------------------------------------------------
// lsf_queue
// Short queue of sum snapshots between the front and the fit sequencer.
// ----------------------------------------------------------------------------
module lsf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lsf_pkg::sums_t push_data,
  input  logic           pop,
  output lsf_pkg::sums_t head,
  output logic           full,
  output logic           empty
);

  lsf_pkg::sums_t                mem [lsf_pkg::Q_DEPTH];
  logic [lsf_pkg::Q_AW-1:0]      wr_ptr_r;
  logic [lsf_pkg::Q_AW-1:0]      rd_ptr_r;
  logic [lsf_pkg::Q_CW-1:0]      fill_r;

  assign full  = (fill_r == lsf_pkg::Q_CW'(lsf_pkg::Q_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == lsf_pkg::Q_AW'(lsf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == lsf_pkg::Q_AW'(lsf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

/* sv/lsf_div.sv */
// ----------------------------------------------------------------------------
// lsf_div
// Bit-serial restoring divider that forms a saturated signed fixed-point
// quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lsf_pkg::div_req_t         req,
  output logic                      done,
  output logic [lsf_pkg::RES_W-1:0] res
);

  localparam int DCNT_W = $clog2(lsf_pkg::DVD_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [DCNT_W-1:0]           cnt_r;
  logic [lsf_pkg::DVD_W-1:0]   dvd_r;
  logic [lsf_pkg::PROD_W:0]    rem_r;
  logic [lsf_pkg::PROD_W-1:0]  den_r;
  logic [lsf_pkg::RES_W:0]     quo_r;
  logic                        ovf_r;
  logic                        neg_r;
  logic [lsf_pkg::PROD_W:0]    rem_sh;
  logic [lsf_pkg::PROD_W:0]    rem_sub;
  logic                        ge;
  logic                        pos_sat;
  logic                        neg_sat;

  assign rem_sh  = {rem_r[lsf_pkg::PROD_W-1:0], dvd_r[lsf_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  assign pos_sat = ovf_r | (quo_r > {1'b0, lsf_pkg::Q_MAX});
  assign neg_sat = ovf_r | (quo_r > {1'b0, lsf_pkg::Q_MIN});

  always_comb begin
    if (neg_r) begin
      res = neg_sat ? lsf_pkg::Q_MIN : (lsf_pkg::RES_W'(0) - quo_r[lsf_pkg::RES_W-1:0]);
    end else begin
      res = pos_sat ? lsf_pkg::Q_MAX : quo_r[lsf_pkg::RES_W-1:0];
    end
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(lsf_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= {req.mag, {lsf_pkg::FRAC_BITS{1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
      neg_r <= req.neg;
      den_r <= req.den;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[lsf_pkg::DVD_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub : rem_sh;
      quo_r <= {quo_r[lsf_pkg::RES_W-1:0], ge};
      ovf_r <= ovf_r | quo_r[lsf_pkg::RES_W];
    end
  end

endmodule

/* sv/lsf_back.sv */
// ----------------------------------------------------------------------------
// lsf_back
// Fit sequencer: forms the cross products with one shared multiplier, the
// numerators and the denominator, drives the divider and holds the result.
// ----------------------------------------------------------------------------
module lsf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  lsf_pkg::sums_t                   q_head,
  output logic                             q_pop,
  output lsf_pkg::div_req_t                div_req,
  input  logic                             div_done,
  input  logic [lsf_pkg::RES_W-1:0]        div_res,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [lsf_pkg::RES_W-1:0] out_slope,
  output logic signed [lsf_pkg::RES_W-1:0] out_intercept,
  output logic                             out_vertical,
  output logic [lsf_pkg::CNT_W-1:0]        out_points_used
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIFF,
    S_CLASS,
    S_WAIT_MEAN,
    S_WAIT_SLOPE,
    S_WAIT_ICPT,
    S_OUT
  } state_t;

  localparam int MIDX_W = $clog2(lsf_pkg::NUM_MUL);

  state_t                        state_r;
  lsf_pkg::sums_t                sums_r;
  logic [MIDX_W-1:0]             mul_idx_r;
  logic [lsf_pkg::PROD_W-1:0]    p_r [lsf_pkg::NUM_MUL];
  logic [lsf_pkg::PROD_W:0]      den_r;
  logic [lsf_pkg::PROD_W:0]      num_s_r;
  logic [lsf_pkg::PROD_W:0]      num_i_r;
  logic [lsf_pkg::RES_W-1:0]     slope_r;
  logic [lsf_pkg::RES_W-1:0]     icpt_r;
  logic                          vert_r;
  lsf_pkg::div_req_t             div_req_r;
  logic                          out_valid_r;
  logic [lsf_pkg::RES_W-1:0]     out_slope_r;
  logic [lsf_pkg::RES_W-1:0]     out_icpt_r;
  logic                          out_vert_r;
  logic [lsf_pkg::CNT_W-1:0]     out_used_r;
  logic [lsf_pkg::SX_W-1:0]      mul_a;
  logic [lsf_pkg::SXX_W-1:0]     mul_b;
  logic                          div_start;
  logic                          out_load;

  function automatic logic [lsf_pkg::PROD_W-1:0] mag_of(input logic [lsf_pkg::PROD_W:0] v);
    logic [lsf_pkg::PROD_W:0] t;
    t = v[lsf_pkg::PROD_W] ? ('0 - v) : v;
    return t[lsf_pkg::PROD_W-1:0];
  endfunction

  always_comb begin
    case (mul_idx_r)
      MIDX_W'(0): begin
        mul_a = lsf_pkg::SX_W'(sums_r.cnt);
        mul_b = sums_r.sxx;
      end
      MIDX_W'(1): begin
        mul_a = sums_r.sx;
        mul_b = lsf_pkg::SXX_W'(sums_r.sx);
      end
      MIDX_W'(2): begin
        mul_a = lsf_pkg::SX_W'(sums_r.cnt);
        mul_b = sums_r.sxy;
      end
      MIDX_W'(3): begin
        mul_a = sums_r.sx;
        mul_b = lsf_pkg::SXX_W'(sums_r.sy);
      end
      MIDX_W'(4): begin
        mul_a = sums_r.sy;
        mul_b = sums_r.sxx;
      end
      default: begin
        mul_a = sums_r.sx;
        mul_b = sums_r.sxy;
      end
    endcase
  end

  assign div_start       = ((state_r == S_CLASS) && (sums_r.cnt != '0)) ||
                           ((state_r == S_WAIT_SLOPE) && div_done);
  assign out_load        = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign q_pop           = (state_r == S_IDLE) & ~q_empty;
  assign div_req         = div_req_r;
  assign out_valid       = out_valid_r;
  assign out_slope       = out_slope_r;
  assign out_intercept   = out_icpt_r;
  assign out_vertical    = out_vert_r;
  assign out_points_used = out_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
      mul_idx_r       <= '0;
    end else begin
      div_req_r.start <= div_start;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            sums_r    <= q_head;
            mul_idx_r <= '0;
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          p_r[mul_idx_r] <= mul_a * mul_b;
          if (mul_idx_r == MIDX_W'(lsf_pkg::NUM_MUL - 1)) begin
            state_r <= S_DIFF;
          end else begin
            mul_idx_r <= mul_idx_r + 1'b1;
          end
        end
        S_DIFF: begin
          den_r   <= {1'b0, p_r[0]} - {1'b0, p_r[1]};
          num_s_r <= {1'b0, p_r[2]} - {1'b0, p_r[3]};
          num_i_r <= {1'b0, p_r[4]} - {1'b0, p_r[5]};
          state_r <= S_CLASS;
        end
        S_CLASS: begin
          if (sums_r.cnt == '0) begin
            vert_r  <= 1'b1;
            slope_r <= lsf_pkg::SLOPE_INF;
            icpt_r  <= '0;
            state_r <= S_OUT;
          end else if (den_r[lsf_pkg::PROD_W] || den_r == '0) begin
            vert_r          <= 1'b1;
            slope_r         <= lsf_pkg::SLOPE_INF;
            div_req_r.neg   <= 1'b0;
            div_req_r.mag   <= lsf_pkg::PROD_W'(sums_r.sy);
            div_req_r.den   <= lsf_pkg::PROD_W'(sums_r.cnt);
            state_r         <= S_WAIT_MEAN;
          end else begin
            vert_r          <= 1'b0;
            div_req_r.neg   <= num_s_r[lsf_pkg::PROD_W];
            div_req_r.mag   <= mag_of(num_s_r);
            div_req_r.den   <= den_r[lsf_pkg::PROD_W-1:0];
            state_r         <= S_WAIT_SLOPE;
          end
        end
        S_WAIT_MEAN: begin
          if (div_done) begin
            icpt_r  <= div_res;
            state_r <= S_OUT;
          end
        end
        S_WAIT_SLOPE: begin
          if (div_done) begin
            slope_r         <= div_res;
            div_req_r.neg   <= num_i_r[lsf_pkg::PROD_W];
            div_req_r.mag   <= mag_of(num_i_r);
            div_req_r.den   <= den_r[lsf_pkg::PROD_W-1:0];
            state_r         <= S_WAIT_ICPT;
          end
        end
        S_WAIT_ICPT: begin
          if (div_done) begin
            icpt_r  <= div_res;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_slope_r <= slope_r;
            out_icpt_r  <= icpt_r;
            out_vert_r  <= vert_r;
            out_used_r  <= sums_r.cnt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/least_squares_line_fit_top.sv */
// One point per cycle is accepted while in_stall is low; the sums update in that cycle.
// A fit starts when its snapshot reaches the sequencer: six products on one multiplier,
// a difference and a classify step, then two serial divisions, or one (mean of y) when
// the denominator is not positive, and none for an empty set.
// A two-entry snapshot queue lets the next set stream in while a fit runs.
// Reset (synchronous, active low) clears the sums, empties the queue and idles the fit.
// ----------------------------------------------------------------------------
// least_squares_line_fit_top
// Streaming ordinary least-squares line fit with saturated fixed-point results.
// ----------------------------------------------------------------------------
module least_squares_line_fit_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lsf_pkg::PT_W-1:0]         in_point_x,
  input  logic [lsf_pkg::PT_W-1:0]         in_point_y,
  input  logic                             in_has_point,
  input  logic                             in_last_point,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [lsf_pkg::RES_W-1:0] out_slope,
  output logic signed [lsf_pkg::RES_W-1:0] out_intercept,
  output logic                             out_vertical,
  output logic [lsf_pkg::CNT_W-1:0]        out_points_used
);

  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  lsf_pkg::sums_t             q_data;
  lsf_pkg::sums_t             q_head;
  lsf_pkg::div_req_t          div_req;
  logic                       div_done;
  logic [lsf_pkg::RES_W-1:0]  div_res;

  lsf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_has_point  (in_has_point),
    .in_last_point (in_last_point),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  lsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  lsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .res   (div_res)
  );

  lsf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .div_req         (div_req),
    .div_done        (div_done),
    .div_res         (div_res),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slope       (out_slope),
    .out_intercept   (out_intercept),
    .out_vertical    (out_vertical),
    .out_points_used (out_points_used)
  );

endmodule

/* test/least_squares_line_fit_top_test.sv */
// ----------------------------------------------------------------------------
// least_squares_line_fit_top_test
// Self-checking testbench for the streaming least-squares line fit. A short
// table of directed point sets covers the empty set, single points, exact
// lines, saturated intercepts, zero denominators and ignored items. Random
// point sets follow. Each fit is compared field by field with the fit its
// table row gives, or else with a predictor that folds each accepted request
// into exact integer sums. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module least_squares_line_fit_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int TOTAL_ITEMS    = 750;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [lsf_pkg::RES_W-1:0] slope;
    logic [lsf_pkg::RES_W-1:0] intercept;
    logic                      vertical;
    logic [lsf_pkg::CNT_W-1:0] used;
  } fit_t;

  typedef struct packed {
    logic [lsf_pkg::PT_W-1:0] x;
    logic [lsf_pkg::PT_W-1:0] y;
    logic                     has;
    logic                     last;
    logic                     typed;
    fit_t                     want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [lsf_pkg::PT_W-1:0] in_point_x = '0;
  logic [lsf_pkg::PT_W-1:0] in_point_y = '0;
  logic in_has_point = 1'b0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [lsf_pkg::RES_W-1:0] out_slope;
  logic signed [lsf_pkg::RES_W-1:0] out_intercept;
  logic out_vertical;
  logic [lsf_pkg::CNT_W-1:0] out_points_used;

  fit_t pending_fits[$];
  int mismatches = 0;
  int set_count = 0;
  longint acc_x = 0;
  longint acc_y = 0;
  longint acc_xy = 0;
  longint acc_xx = 0;
  bit calm_sender = 1'b0;
  bit calm_receiver = 1'b0;
  int stall_left = 0;
  int rx_cycle = 0;
  int rx_roll;
  int quiet_cycles = 0;
  int items_sent = 0;

  least_squares_line_fit_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_has_point    (in_has_point),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slope       (out_slope),
    .out_intercept   (out_intercept),
    .out_vertical    (out_vertical),
    .out_points_used (out_points_used)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [lsf_pkg::RES_W-1:0] q_divide(input longint num, input longint den);
    bit neg;
    longint unsigned mag, dv, whole, rem, frac, total;
    neg = num < 0;
    mag = neg ? longint'(-num) : num;
    dv = den;
    if (dv == 0) return '0;
    whole = mag / dv;
    rem = mag % dv;
    frac = 0;
    for (int i = 0; i < lsf_pkg::FRAC_BITS; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= dv) begin
        rem = rem - dv;
        frac = frac | 1;
      end
    end
    if (whole > 64'hFFFF_FFFF) whole = 64'h1_0000_0000;
    total = (whole << lsf_pkg::FRAC_BITS) | frac;
    if (!neg) begin
      if (total > 64'h7FFF_FFFF) total = 64'h7FFF_FFFF;
      return total[lsf_pkg::RES_W-1:0];
    end
    if (total > 64'h8000_0000) total = 64'h8000_0000;
    total = 64'd0 - total;
    return total[lsf_pkg::RES_W-1:0];
  endfunction

  function automatic bit fold_point(input logic [lsf_pkg::PT_W-1:0] x,
                                    input logic [lsf_pkg::PT_W-1:0] y,
                                    input logic has, input logic last, output fit_t fit);
    longint n, sx, sy, sxy, sxx, den;
    fit = '0;
    if (has && set_count < lsf_pkg::MAX_SET_POINTS) begin
      set_count++;
      acc_x += longint'(x);
      acc_y += longint'(y);
      acc_xy += longint'(x) * longint'(y);
      acc_xx += longint'(x) * longint'(x);
    end
    if (!last) return 1'b0;
    n = set_count;
    sx = acc_x;
    sy = acc_y;
    sxy = acc_xy;
    sxx = acc_xx;
    fit.slope = lsf_pkg::SLOPE_INF;
    fit.vertical = 1'b1;
    if (n != 0) begin
      den = n * sxx - sx * sx;
      if (den <= 0) begin
        fit.intercept = q_divide(sy, n);
      end else begin
        fit.slope = q_divide(n * sxy - sx * sy, den);
        fit.intercept = q_divide(sy * sxx - sx * sxy, den);
        fit.vertical = 1'b0;
      end
    end
    fit.used = set_count[lsf_pkg::CNT_W-1:0];
    set_count = 0;
    acc_x = 0;
    acc_y = 0;
    acc_xy = 0;
    acc_xx = 0;
    return 1'b1;
  endfunction

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_sender || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_request(input logic [lsf_pkg::PT_W-1:0] x,
                              input logic [lsf_pkg::PT_W-1:0] y,
                              input logic has, input logic last,
                              input logic typed, input fit_t typed_fit);
    fit_t predicted;
    bit produced;
    int gap;
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_has_point <= has;
    in_last_point <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    produced = fold_point(x, y, has, last, predicted);
    if (produced) pending_fits.push_back(typed ? typed_fit : predicted);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_fits();
    in_valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_set();
    int roll, n, mode, k;
    logic [lsf_pkg::PT_W-1:0] x0, px, py;
    bit close_on_point;
    roll = $urandom_range(0, 99);
    if (roll < 5) n = 0;
    else if (roll < 80) n = $urandom_range(1, 8);
    else if (roll < 95) n = $urandom_range(9, 40);
    else n = $urandom_range(41, 200);
    if (n > TOTAL_ITEMS - items_sent) n = TOTAL_ITEMS - items_sent;
    mode = $urandom_range(0, 9);
    x0 = lsf_pkg::PT_W'($urandom);
    close_on_point = (n > 0) && ($urandom_range(0, 9) < 7);
    calm_sender = ($urandom_range(0, 4) == 0);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_request(lsf_pkg::PT_W'($urandom), lsf_pkg::PT_W'($urandom), 1'b0, 1'b0,
                     1'b0, '0);
      case (mode)
        0: begin
          px = x0;
          py = lsf_pkg::PT_W'($urandom);
        end
        1: begin
          px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          py = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        2: begin
          px = x0 + lsf_pkg::PT_W'($urandom_range(0, 3));
          py = lsf_pkg::PT_W'($urandom);
        end
        default: begin
          px = lsf_pkg::PT_W'($urandom);
          py = lsf_pkg::PT_W'($urandom);
        end
      endcase
      send_request(px, py, 1'b1, close_on_point && (k == n - 1), 1'b0, '0);
    end
    if (!close_on_point) begin
      send_request(lsf_pkg::PT_W'($urandom), lsf_pkg::PT_W'($urandom), 1'b0, 1'b1,
                   1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) calm_receiver = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (calm_receiver) begin
        out_stall <= 1'b0;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 70) begin
          out_stall <= 1'b0;
        end else if (rx_roll < 95) begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(10, 50);
        end
      end
    end
  end

  always @(posedge clk) begin
    fit_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_fits.size() == 0) begin
        report_mismatch("fit result with no request pending");
      end else begin
        want = pending_fits.pop_front();
        if (out_slope !== want.slope)
          report_mismatch($sformatf("slope %h, want %h", out_slope, want.slope));
        if (out_intercept !== want.intercept)
          report_mismatch($sformatf("intercept %h, want %h", out_intercept, want.intercept));
        if (out_vertical !== want.vertical)
          report_mismatch($sformatf("vertical %b, want %b", out_vertical, want.vertical));
        if (out_points_used !== want.used)
          report_mismatch($sformatf("points_used %0d, want %0d", out_points_used, want.used));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [21];
    plan = '{
      '{8'h00, 8'h00, 1'b0, 1'b1, 1'b1, '{lsf_pkg::SLOPE_INF, 32'h0000_0000, 1'b1, 11'd0}},
      '{8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, '{lsf_pkg::SLOPE_INF, 32'h00FF_0000, 1'b1, 11'd1}},
      '{8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, '{32'h0001_0000, 32'h0000_0000, 1'b0, 11'd2}},
      '{8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, '0},
      '{8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, '{32'hFFFF_0000, 32'h00FF_0000, 1'b0, 11'd2}},
      '{8'hFE, 8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, '{32'h00FF_0000, lsf_pkg::Q_MIN, 1'b0, 11'd2}},
      '{8'hFE, 8'hFF, 1'b1, 1'b0, 1'b0, '0},
      '{8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, '{32'hFF01_0000, lsf_pkg::Q_MAX, 1'b0, 11'd2}},
      '{8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, '{lsf_pkg::SLOPE_INF, 32'h007F_8000, 1'b1, 11'd2}},
      '{8'hAA, 8'h55, 1'b0, 1'b0, 1'b0, '0},
      '{8'h55, 8'hAA, 1'b0, 1'b0, 1'b0, '0},
      '{8'h03, 8'h0A, 1'b1, 1'b0, 1'b0, '0},
      '{8'h07, 8'hC8, 1'b1, 1'b0, 1'b0, '0},
      '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h64, 8'h32, 1'b1, 1'b0, 1'b0, '0},
      '{8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, '0},
      '{8'h80, 8'h01, 1'b1, 1'b0, 1'b0, '0},
      '{8'h7F, 8'hFE, 1'b1, 1'b1, 1'b0, '0}
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < $size(plan); k++)
      send_request(plan[k].x, plan[k].y, plan[k].has, plan[k].last, plan[k].typed,
                   plan[k].want);
    send_request(8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
                 '{lsf_pkg::SLOPE_INF, 32'h0000_0000, 1'b1, 11'd0});
    wait_all_fits();
    while (items_sent < TOTAL_ITEMS) begin
      send_random_set();
      if (items_sent >= TOTAL_ITEMS / 2 && items_sent < TOTAL_ITEMS / 2 + 20)
        wait_all_fits();
    end
    wait_all_fits();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_fits.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/lsf_pkg.sv
sv/lsf_front.sv
sv/lsf_queue.sv
sv/lsf_div.sv
sv/lsf_back.sv
sv/least_squares_line_fit_top.sv
test/least_squares_line_fit_top_test.sv
